@@ design/bce_pkg.sv @@
// Shared types, constants and the line step function of the Bezier evaluator.
`default_nettype none
package bce_pkg;
  localparam int NPTS  = 8;   // control points held, degree up to 7
  localparam int AXES  = 3;
  localparam int CW    = 32;  // control point / position width
  localparam int DW    = 40;  // derivative width
  localparam int W     = 42;  // working width of the line
  localparam int TW    = 17;  // curve parameter width
  localparam int DEG_W = 3;

  localparam logic [TW-1:0] T_ONE = 17'h10000;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic OP_LERP = 1'b0;
  localparam logic OP_DIFF = 1'b1;

  localparam logic [1:0] QTY_ACC = 2'd0;
  localparam logic [1:0] QTY_VEL = 2'd1;
  localparam logic [1:0] QTY_POS = 2'd2;

  typedef struct packed {
    logic                     cmd;
    logic [DEG_W-1:0]         point_index;
    logic signed [CW-1:0]     point_x;
    logic signed [CW-1:0]     point_y;
    logic signed [CW-1:0]     point_z;
    logic [TW-1:0]            param_t;
  } in_item_t;

  typedef struct packed {
    logic                     pos_valid;
    logic signed [CW-1:0]     pos_x;
    logic signed [CW-1:0]     pos_y;
    logic signed [CW-1:0]     pos_z;
    logic                     vel_valid;
    logic signed [DW-1:0]     vel_x;
    logic signed [DW-1:0]     vel_y;
    logic signed [DW-1:0]     vel_z;
    logic                     acc_valid;
    logic signed [DW-1:0]     acc_x;
    logic signed [DW-1:0]     acc_y;
    logic signed [DW-1:0]     acc_z;
  } out_item_t;

  typedef struct packed {
    logic             pt_write;
    logic             start;
    logic             load;
    logic             step;
    logic             op;
    logic [DEG_W-1:0] scale;
    logic             active;
    logic             capture;
    logic [1:0]       qty;
    logic             publish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // One element of a line pass: a lerp toward b, or a scaled difference.
  function automatic logic signed [W-1:0] step_value(
    input logic signed [W-1:0] a,
    input logic signed [W-1:0] b,
    input logic                op,
    input logic [DEG_W-1:0]    scale,
    input logic [TW-1:0]       t
  );
    logic signed [W:0]       diff;
    logic signed [TW:0]      k;
    logic signed [W+TW+1:0]  prod;
    logic signed [W+TW+1:0]  sh;
    diff = {b[W-1], b} - {a[W-1], a};
    if (op == OP_DIFF) begin
      k = $signed({{(TW+1-DEG_W){1'b0}}, scale});
    end else begin
      k = $signed({1'b0, t});
    end
    prod = diff * k;
    sh   = prod >>> 16;
    if (op == OP_DIFF) begin
      return prod[W-1:0];
    end
    return a + sh[W-1:0];
  endfunction
endpackage
`default_nettype wire

@@ design/bce_ctrl.sv @@
// Sequencer: loads, difference passes, de Casteljau passes and result hand-off.
`default_nettype none
module bce_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_cmd_i,
  input  wire logic [bce_pkg::DEG_W-1:0] deg_i,
  input  wire bce_pkg::dp_status_t       status_i,
  output logic                           in_stall_o,
  output bce_pkg::dp_cmd_t               cmd_o
);
  import bce_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_STEP = 3'd2;
  localparam logic [2:0] ST_CAPT = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [1:0]       qty_q, qty_d;
  logic [DEG_W-1:0] round_q, round_d;
  logic [DEG_W-1:0] step_q, step_d;
  logic [DEG_W-1:0] ndiff;
  logic             accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    case (qty_q)
      QTY_ACC: ndiff = 3'd2;
      QTY_VEL: ndiff = 3'd1;
      default: ndiff = 3'd0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    qty_d   = qty_q;
    round_d = round_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.scale  = deg_i - round_q;
    cmd_o.op     = (round_q < ndiff) ? OP_DIFF : OP_LERP;
    cmd_o.active = (step_q < cmd_o.scale);
    cmd_o.qty    = qty_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_cmd_i == CMD_LOAD) begin
          cmd_o.pt_write = 1'b1;
        end else if (accept) begin
          cmd_o.start = 1'b1;
          if (deg_i == '0) begin
            state_d = ST_DONE;
          end else begin
            qty_d   = (deg_i >= 3'd2) ? QTY_ACC : QTY_VEL;
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        round_d    = '0;
        step_d     = '0;
        state_d    = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + 3'd1;
        // each pass rotates the whole line once; n passes per quantity
        if (step_q == 3'(NPTS - 1)) begin
          round_d = round_q + 3'd1;
          if (round_q == deg_i - 3'd1) begin
            state_d = ST_CAPT;
          end
        end
      end
      ST_CAPT: begin
        cmd_o.capture = 1'b1;
        if (qty_q == QTY_POS) begin
          state_d = ST_DONE;
        end else begin
          qty_d   = qty_q + 2'd1;
          state_d = ST_LOAD;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      qty_q   <= QTY_ACC;
      round_q <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      qty_q   <= qty_d;
      round_q <= round_d;
      step_q  <= step_d;
    end
  end
endmodule
`default_nettype wire

@@ design/bce_datapath.sv @@
// Point store, rotating work line with one multiplier per axis, result registers.
`default_nettype none
module bce_datapath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire bce_pkg::in_item_t         in_item_i,
  input  wire logic [bce_pkg::DEG_W-1:0] deg_i,
  input  wire bce_pkg::dp_cmd_t          cmd_i,
  input  wire logic                      out_stall_i,
  output bce_pkg::dp_status_t            status_o,
  output logic                           out_valid_o,
  output bce_pkg::out_item_t             out_item_o
);
  import bce_pkg::*;

  logic signed [CW-1:0] store_q [AXES][NPTS];
  logic signed [W-1:0]  line_q  [AXES][NPTS];
  logic signed [CW-1:0] pos_q   [AXES];
  logic signed [DW-1:0] vel_q   [AXES];
  logic signed [DW-1:0] acc_q   [AXES];
  logic [TW-1:0]        t_q;
  logic [TW-1:0]        t_sat;
  logic signed [CW-1:0] pt_in   [AXES];
  logic                 out_valid_q;
  out_item_t            out_q;

  assign t_sat    = (in_item_i.param_t > T_ONE) ? T_ONE : in_item_i.param_t;
  assign pt_in[0] = in_item_i.point_x;
  assign pt_in[1] = in_item_i.point_y;
  assign pt_in[2] = in_item_i.point_z;

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_write) begin
      for (int a = 0; a < AXES; a++) begin
        store_q[a][in_item_i.point_index] <= pt_in[a];
      end
    end
    if (cmd_i.start) begin
      t_q <= t_sat;
      for (int a = 0; a < AXES; a++) begin
        pos_q[a] <= '0;
        vel_q[a] <= '0;
        acc_q[a] <= '0;
      end
    end
    if (cmd_i.load) begin
      for (int a = 0; a < AXES; a++) begin
        for (int i = 0; i < NPTS; i++) begin
          line_q[a][i] <= W'(store_q[a][i]);
        end
      end
    end
    if (cmd_i.step) begin
      // head pair feeds the unit; result goes to the tail, idle slots recirculate
      for (int a = 0; a < AXES; a++) begin
        for (int i = 0; i < NPTS - 1; i++) begin
          line_q[a][i] <= line_q[a][i+1];
        end
        line_q[a][NPTS-1] <= cmd_i.active ?
            step_value(line_q[a][0], line_q[a][1], cmd_i.op, cmd_i.scale, t_q) :
            line_q[a][0];
      end
    end
    if (cmd_i.capture) begin
      for (int a = 0; a < AXES; a++) begin
        case (cmd_i.qty)
          QTY_ACC: acc_q[a] <= line_q[a][0][DW-1:0];
          QTY_VEL: vel_q[a] <= line_q[a][0][DW-1:0];
          default: pos_q[a] <= line_q[a][0][CW-1:0];
        endcase
      end
    end
    if (cmd_i.publish) begin
      out_q.pos_valid <= (deg_i >= 3'd1);
      out_q.vel_valid <= (deg_i >= 3'd1);
      out_q.acc_valid <= (deg_i >= 3'd2);
      out_q.pos_x <= pos_q[0];
      out_q.pos_y <= pos_q[1];
      out_q.pos_z <= pos_q[2];
      out_q.vel_x <= vel_q[0];
      out_q.vel_y <= vel_q[1];
      out_q.vel_z <= vel_q[2];
      out_q.acc_x <= acc_q[0];
      out_q.acc_y <= acc_q[1];
      out_q.acc_z <= acc_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ design/bezier_curve_evaluator.sv @@
// Loads: a load is written to the point store without stalling the input; an evaluate of
// degree n stalls the input from acceptance until its result enters the output register.
// Throughput: one evaluate at a time, the next item can be taken as soon as the result
// is in the output register; each pass rotates the 8-entry work line once through one
// lerp/difference multiplier per axis, n passes per quantity; a stalled result holds it.
// Reset: async active low; degree clears to 0, control points undefined until loaded.
`default_nettype none
module bezier_curve_evaluator (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire bce_pkg::in_item_t         in_item_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output bce_pkg::out_item_t             out_item_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [bce_pkg::DEG_W-1:0] cfg_data_i
);
  import bce_pkg::*;

  logic [DEG_W-1:0] deg_q;
  dp_cmd_t          cmd;
  dp_status_t       status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      deg_q <= cfg_data_i;
    end
  end

  bce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_item_i.cmd),
    .deg_i      (deg_q),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  bce_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .deg_i       (deg_q),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

`ifndef ASSERT_OFF
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_item_i.cmd == CMD_EVAL) |=> in_stall_o)
    else $error("evaluate accepted but input not stalled");
  a_acc_implies_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.acc_valid) |-> out_item_o.pos_valid)
    else $error("acceleration valid without position valid");
  a_acc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.acc_valid) |->
      (out_item_o.acc_x == '0 && out_item_o.acc_y == '0 && out_item_o.acc_z == '0))
    else $error("invalid acceleration not zero");
`endif
endmodule
`default_nettype wire
